FILE: src/shtrk_pkg.sv
// Package for the sensor health tracker: sizes, health and fault codes,
// status and function codes, register indexes and sequencer states.
// No dependencies.
`default_nettype none

package shtrk_pkg;

    localparam int DISTANCE_SENSORS = 4;
    localparam int SENSOR_COUNT     = DISTANCE_SENSORS + 1;
    localparam int IDX_W            = $clog2(SENSOR_COUNT);

    localparam logic [7:0]  STREAK_MAX = 8'hFF;
    localparam logic [31:0] AGE_MAX    = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        H_STARTING   = 3'd0,
        H_HEALTHY    = 3'd1,
        H_DEGRADED   = 3'd2,
        H_FAULTED    = 3'd3,
        H_RECOVERING = 3'd4
    } health_t;

    typedef enum logic [1:0] {
        F_NONE      = 2'd0,
        F_BUS_STUCK = 2'd1,
        F_NO_ACK    = 2'd2,
        F_STALE     = 2'd3
    } fault_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BUS_STUCK = 2'd1,
        ST_BUSY_SKIP = 2'd2,
        ST_NO_ACK    = 2'd3
    } status_t;

    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [2:0] REG_FAULT_THRESHOLD      = 3'd0;
    localparam logic [2:0] REG_RECOVERY_SUCCESSES   = 3'd1;
    localparam logic [2:0] REG_RECOVERY_COOLDOWN_MS = 3'd2;
    localparam logic [2:0] REG_DISTANCE_FRESH_MS    = 3'd3;
    localparam logic [2:0] REG_ANGLE_FRESH_MS       = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINCE,
        S_COOL,
        S_UPD,
        S_TAGE,
        S_TCMP,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

FILE: src/sensor_health_tracker_unit.sv
// Sensor health tracker top level: per-sensor record, sequencer and one
// shared 64-bit subtract/compare unit. Depends on shtrk_pkg.
`default_nettype none

// Usage: an item transfers at a rising edge with start high and busy low.
// A read outcome (func 0) produces one result, through the update and
// emit steps; a bus-stuck outcome first passes the since and cooldown
// steps for the recovery cooldown check. A freshness tick (func 1)
// produces one result per sensor, sensor 0 first; busy stays high
// through the final sensor's emit step and last marks the final result.
// The pace is set by the single shared 64-bit subtractor: each sensor's
// age takes one pass and its compare with the freshness limit another,
// followed by the emit step that loads the result register. A read
// outcome naming an unknown sensor is taken, changes nothing and produces
// no result. Each result is shown for exactly one cycle with result_valid
// high; the receiver cannot stall it, so take it when it comes. A new
// item may transfer in the cycle of the final result.
// Configuration writes take effect at once and must only be issued while
// busy is low and no result is pending.
module sensor_health_tracker_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        func,
    input  wire logic [2:0]  sensor,
    input  wire logic [1:0]  status,
    input  wire logic [31:0] reading,
    input  wire logic [15:0] reading_two,
    input  wire logic [63:0] now_ms,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    output logic             result_valid,
    output logic [2:0]       which_sensor,
    output logic [2:0]       health,
    output logic [1:0]       fault_code,
    output logic [7:0]       success_streak,
    output logic [7:0]       failure_streak,
    output logic [31:0]      age_ms,
    output logic             sample_seen,
    output logic [31:0]      last_reading,
    output logic [15:0]      last_reading_two,
    output logic             recover_request,
    output logic             last
);
    import shtrk_pkg::*;

    // Configuration registers
    logic [7:0]  fail_limit_reg;
    logic [7:0]  recover_wins_reg;
    logic [31:0] recovery_cooldown_reg;
    logic [31:0] distance_fresh_reg;
    logic [31:0] angle_fresh_reg;

    // Per-sensor record
    health_t     health_tbl_reg     [SENSOR_COUNT];
    fault_t      fault_tbl_reg      [SENSOR_COUNT];
    logic [7:0]  succ_tbl_reg       [SENSOR_COUNT];
    logic [7:0]  fail_tbl_reg       [SENSOR_COUNT];
    logic        valid_tbl_reg      [SENSOR_COUNT];
    logic [63:0] time_tbl_reg       [SENSOR_COUNT];
    logic [31:0] age_tbl_reg        [SENSOR_COUNT];
    logic [31:0] reading_tbl_reg    [SENSOR_COUNT];
    logic [15:0] reading_two_tbl_reg[SENSOR_COUNT];
    logic [63:0] last_recovery_time_reg;
    logic        recovered_before_reg;

    // Captured item
    logic             func_reg;
    logic [IDX_W-1:0] idx_reg;
    status_t          status_reg;
    logic [31:0]      reading_reg;
    logic [15:0]      reading_two_reg;
    logic [63:0]      now_reg;

    // Working registers
    state_t      state_reg, state_next;
    logic [63:0] diff_reg;
    logic [31:0] age_reg;
    logic        req_reg;

    // Result registers
    logic        result_valid_reg;
    logic [2:0]  which_sensor_reg;
    logic [2:0]  health_out_reg;
    logic [1:0]  fault_out_reg;
    logic [7:0]  succ_out_reg;
    logic [7:0]  fail_out_reg;
    logic [31:0] age_out_reg;
    logic        sample_seen_reg;
    logic [31:0] last_reading_reg;
    logic [15:0] last_reading_two_reg;
    logic        recover_request_reg;
    logic        last_reg;

    logic accept;
    logic known_sensor;
    logic tick_last;

    assign accept       = start && !busy;
    assign known_sensor = 32'(sensor) < SENSOR_COUNT;
    assign tick_last    = idx_reg == IDX_W'(SENSOR_COUNT - 1);

    // ------------------------------------------------------------------
    // Shared subtractor: a - b with borrow out. Used for time differences
    // (clamped to zero on borrow) and for >= compares against limits.
    // ------------------------------------------------------------------
    logic [63:0] op_a, op_b;
    logic [64:0] sub_full;
    logic        sub_borrow;
    logic [63:0] sub_diff;

    always_comb
    begin
        unique case (state_reg)
            S_SINCE:
            begin
                op_a = now_reg;
                op_b = last_recovery_time_reg;
            end
            S_COOL:
            begin
                op_a = diff_reg;
                op_b = {32'd0, recovery_cooldown_reg};
            end
            S_TAGE:
            begin
                op_a = now_reg;
                op_b = time_tbl_reg[idx_reg];
            end
            S_TCMP:
            begin
                op_a = {32'd0, age_reg};
                op_b = (idx_reg == IDX_W'(DISTANCE_SENSORS))
                       ? {32'd0, angle_fresh_reg} : {32'd0, distance_fresh_reg};
            end
            default:
            begin
                op_a = now_reg;
                op_b = diff_reg;
            end
        endcase
    end

    assign sub_full   = {1'b0, op_a} - {1'b0, op_b};
    assign sub_borrow = sub_full[64];
    assign sub_diff   = sub_full[63:0];

    // ------------------------------------------------------------------
    // Read outcome update of the selected entry
    // ------------------------------------------------------------------
    health_t    cur_health;
    logic [7:0] cur_succ, cur_fail, succ_inc, fail_inc;
    health_t    health_next;
    fault_t     fault_next;
    logic [7:0] succ_next, fail_next;
    logic       was_bad;

    assign cur_health = health_tbl_reg[idx_reg];
    assign cur_succ   = succ_tbl_reg[idx_reg];
    assign cur_fail   = fail_tbl_reg[idx_reg];
    assign succ_inc   = (cur_succ == STREAK_MAX) ? cur_succ : cur_succ + 8'd1;
    assign fail_inc   = (cur_fail == STREAK_MAX) ? cur_fail : cur_fail + 8'd1;
    assign was_bad    = (cur_health == H_FAULTED) || (cur_health == H_RECOVERING);

    always_comb
    begin
        health_next = cur_health;
        fault_next  = fault_tbl_reg[idx_reg];
        succ_next   = cur_succ;
        fail_next   = cur_fail;
        unique case (status_reg)
            ST_OK:
            begin
                fault_next = F_NONE;
                fail_next  = 8'd0;
                succ_next  = succ_inc;
                if (was_bad)
                    health_next = (succ_inc >= recover_wins_reg)
                                  ? H_HEALTHY : H_RECOVERING;
                else
                    health_next = H_HEALTHY;
            end
            ST_BUS_STUCK, ST_NO_ACK:
            begin
                fault_next = (status_reg == ST_BUS_STUCK) ? F_BUS_STUCK : F_NO_ACK;
                succ_next  = 8'd0;
                fail_next  = fail_inc;
                if (was_bad || fail_inc >= fail_limit_reg)
                    health_next = H_FAULTED;
                else if (valid_tbl_reg[idx_reg])
                    health_next = H_DEGRADED;
                else
                    health_next = H_STARTING;
            end
            ST_BUSY_SKIP:
            begin
                // hold the record as it is
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (func == FUNC_TICK)
                        state_next = S_TAGE;
                    else if (!known_sensor)
                        state_next = S_IDLE;    // drop: no result
                    else if (status_t'(status) == ST_BUS_STUCK)
                        state_next = S_SINCE;
                    else
                        state_next = S_UPD;
                end
            end
            S_SINCE: state_next = S_COOL;
            S_COOL:  state_next = S_UPD;
            S_UPD:   state_next = S_EMIT;
            S_TAGE:  state_next = S_TCMP;
            S_TCMP:  state_next = S_EMIT;
            S_EMIT:
            begin
                if (func_reg == FUNC_TICK && !tick_last)
                    state_next = S_TAGE;
                else
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Capture the item on transfer; advance the sensor index during a tick
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg        <= func;
            idx_reg         <= (func == FUNC_TICK) ? '0 : IDX_W'(sensor);
            status_reg      <= status_t'(status);
            reading_reg     <= reading;
            reading_two_reg <= reading_two;
            now_reg         <= now_ms;
        end
        else if (state_reg == S_EMIT && func_reg == FUNC_TICK && !tick_last)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end

        if (state_reg == S_SINCE)
            diff_reg <= sub_borrow ? 64'd0 : sub_diff;

        if (state_reg == S_TAGE)
        begin
            if (!valid_tbl_reg[idx_reg])
                age_reg <= AGE_MAX;
            else if (sub_borrow)
                age_reg <= 32'd0;
            else if (|sub_diff[63:32])
                age_reg <= AGE_MAX;
            else
                age_reg <= sub_diff[31:0];
        end
    end

    // Configuration, record and recovery state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_limit_reg         <= 8'd3;
            recover_wins_reg       <= 8'd3;
            recovery_cooldown_reg  <= 32'd5000;
            distance_fresh_reg     <= 32'd100;
            angle_fresh_reg        <= 32'd1000;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                health_tbl_reg[i]      <= H_STARTING;
                fault_tbl_reg[i]       <= F_NONE;
                succ_tbl_reg[i]        <= 8'd0;
                fail_tbl_reg[i]        <= 8'd0;
                valid_tbl_reg[i]       <= 1'b0;
                time_tbl_reg[i]        <= 64'd0;
                age_tbl_reg[i]         <= 32'd0;
                reading_tbl_reg[i]     <= 32'd0;
                reading_two_tbl_reg[i] <= 16'd0;
            end
            last_recovery_time_reg <= 64'd0;
            recovered_before_reg   <= 1'b0;
            req_reg                <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_FAULT_THRESHOLD:      fail_limit_reg         <= cfg_wdata[7:0];
                    REG_RECOVERY_SUCCESSES:   recover_wins_reg       <= cfg_wdata[7:0];
                    REG_RECOVERY_COOLDOWN_MS: recovery_cooldown_reg  <= cfg_wdata;
                    REG_DISTANCE_FRESH_MS:    distance_fresh_reg     <= cfg_wdata;
                    REG_ANGLE_FRESH_MS:       angle_fresh_reg        <= cfg_wdata;
                    default:
                    begin
                        // no register at this index: drop the write
                    end
                endcase
            end

            if (accept)
                req_reg <= 1'b0;

            // Grant a recovery unless the cooldown since the last one is
            // still running
            if (state_reg == S_COOL && (!recovered_before_reg || !sub_borrow))
            begin
                req_reg                <= 1'b1;
                last_recovery_time_reg <= now_reg;
                recovered_before_reg   <= 1'b1;
            end

            if (state_reg == S_UPD)
            begin
                health_tbl_reg[idx_reg] <= health_next;
                fault_tbl_reg[idx_reg]  <= fault_next;
                succ_tbl_reg[idx_reg]   <= succ_next;
                fail_tbl_reg[idx_reg]   <= fail_next;
                if (status_reg == ST_OK)
                begin
                    valid_tbl_reg[idx_reg]       <= 1'b1;
                    time_tbl_reg[idx_reg]        <= now_reg;
                    reading_tbl_reg[idx_reg]     <= reading_reg;
                    reading_two_tbl_reg[idx_reg] <= reading_two_reg;
                end
            end

            // Stale check: for a sampled sensor, age at or over the limit degrades or faults
            if (state_reg == S_TCMP)
            begin
                age_tbl_reg[idx_reg] <= age_reg;
                if (valid_tbl_reg[idx_reg] && !sub_borrow)
                begin
                    if (fail_tbl_reg[idx_reg] >= fail_limit_reg)
                    begin
                        health_tbl_reg[idx_reg] <= H_FAULTED;
                        fault_tbl_reg[idx_reg]  <= F_STALE;
                    end
                    else
                    begin
                        health_tbl_reg[idx_reg] <= H_DEGRADED;
                    end
                end
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= (state_reg == S_EMIT);
    end

    // Result payload: load from the updated record
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT)
        begin
            which_sensor_reg     <= 3'(idx_reg);
            health_out_reg       <= health_tbl_reg[idx_reg];
            fault_out_reg        <= fault_tbl_reg[idx_reg];
            succ_out_reg         <= succ_tbl_reg[idx_reg];
            fail_out_reg         <= fail_tbl_reg[idx_reg];
            age_out_reg          <= age_tbl_reg[idx_reg];
            sample_seen_reg      <= valid_tbl_reg[idx_reg];
            last_reading_reg     <= reading_tbl_reg[idx_reg];
            last_reading_two_reg <= reading_two_tbl_reg[idx_reg];
            recover_request_reg  <= (func_reg == FUNC_EVENT) && req_reg;
            last_reg             <= (func_reg == FUNC_EVENT) || tick_last;
        end
    end

    assign result_valid     = result_valid_reg;
    assign which_sensor     = which_sensor_reg;
    assign health           = health_out_reg;
    assign fault_code       = fault_out_reg;
    assign success_streak   = succ_out_reg;
    assign failure_streak   = fail_out_reg;
    assign age_ms           = age_out_reg;
    assign sample_seen      = sample_seen_reg;
    assign last_reading     = last_reading_reg;
    assign last_reading_two = last_reading_two_reg;
    assign recover_request  = recover_request_reg;
    assign last             = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_strobe_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> $past(state_reg == S_EMIT))
        else $error("result strobe without an emit step");

    a_req_only_bus_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && recover_request_reg)
            |-> (func_reg == FUNC_EVENT && status_reg == ST_BUS_STUCK))
        else $error("recovery request on a result that is not bus stuck");

    a_req_records_time: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && recover_request_reg)
            |-> (recovered_before_reg && last_recovery_time_reg == now_reg))
        else $error("granted recovery not recorded");

    a_tick_last_sensor: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && last_reg && func_reg == FUNC_TICK)
            |-> (which_sensor_reg == 3'(SENSOR_COUNT - 1)))
        else $error("tick marked last before the final sensor");

endmodule

`default_nettype wire

FILE: tb/shtrk_tb_pkg.sv
// Scoreboard for the sensor health tracker testbench: per-sensor health
// record, the expected-report queue and field-wise report compare.
// Depends on shtrk_pkg.
package shtrk_tb_pkg;

    import shtrk_pkg::*;

    typedef struct packed {
        logic [2:0]  which_sensor;
        logic [2:0]  health;
        logic [1:0]  fault_code;
        logic [7:0]  success_streak;
        logic [7:0]  failure_streak;
        logic [31:0] age_ms;
        logic        sample_seen;
        logic [31:0] last_reading;
        logic [15:0] last_reading_two;
        logic        recover_request;
        logic        last;
    } health_report_t;

    class sensor_health_book;

        logic [7:0]     fail_limit;
        logic [7:0]     recover_wins;
        logic [31:0]    cooldown_ms;
        logic [31:0]    distance_fresh_ms;
        logic [31:0]    angle_fresh_ms;

        health_t        health_tbl      [SENSOR_COUNT];
        fault_t         fault_tbl       [SENSOR_COUNT];
        logic [7:0]     wins            [SENSOR_COUNT];
        logic [7:0]     misses          [SENSOR_COUNT];
        logic           sampled         [SENSOR_COUNT];
        logic [63:0]    sample_stamp    [SENSOR_COUNT];
        logic [31:0]    age_tbl         [SENSOR_COUNT];
        logic [31:0]    reading_tbl     [SENSOR_COUNT];
        logic [15:0]    reading_two_tbl [SENSOR_COUNT];
        logic [63:0]    last_recovery_ms;
        logic           recovered_once;

        health_report_t expected_reports [$];
        int             failures;

        function new();
            fail_limit           = 8'd3;
            recover_wins         = 8'd3;
            cooldown_ms          = 32'd5000;
            distance_fresh_ms    = 32'd100;
            angle_fresh_ms       = 32'd1000;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                health_tbl[i]      = H_STARTING;
                fault_tbl[i]       = F_NONE;
                wins[i]            = '0;
                misses[i]          = '0;
                sampled[i]         = 1'b0;
                sample_stamp[i]    = '0;
                age_tbl[i]         = '0;
                reading_tbl[i]     = '0;
                reading_two_tbl[i] = '0;
            end
            last_recovery_ms = '0;
            recovered_once   = 1'b0;
            failures         = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_FAULT_THRESHOLD:      fail_limit           = val[7:0];
                REG_RECOVERY_SUCCESSES:   recover_wins         = val[7:0];
                REG_RECOVERY_COOLDOWN_MS: cooldown_ms          = val;
                REG_DISTANCE_FRESH_MS:    distance_fresh_ms    = val;
                REG_ANGLE_FRESH_MS:       angle_fresh_ms       = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function health_report_t snapshot(int s, logic req, logic fin);
            health_report_t r;
            r.which_sensor     = 3'(s);
            r.health           = health_tbl[s];
            r.fault_code       = fault_tbl[s];
            r.success_streak   = wins[s];
            r.failure_streak   = misses[s];
            r.age_ms           = age_tbl[s];
            r.sample_seen      = sampled[s];
            r.last_reading     = reading_tbl[s];
            r.last_reading_two = reading_two_tbl[s];
            r.recover_request  = req;
            r.last             = fin;
            return r;
        endfunction

        function string show(health_report_t r);
            return $sformatf({"sensor=%0d health=%0d fault=%0d ok=%0d fail=%0d age=%h ",
                              "sample=%b rd=%h rd2=%h req=%b last=%b"},
                             r.which_sensor, r.health, r.fault_code, r.success_streak,
                             r.failure_streak, r.age_ms, r.sample_seen, r.last_reading,
                             r.last_reading_two, r.recover_request, r.last);
        endfunction

        function void complain(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        // Failed read: streak bookkeeping and the faulted/degraded/starting pick.
        function void count_failure(int s, fault_t code);
            logic bad;
            bad = (health_tbl[s] == H_FAULTED) || (health_tbl[s] == H_RECOVERING);
            fault_tbl[s] = code;
            wins[s]      = '0;
            if (misses[s] < STREAK_MAX)
                misses[s]++;
            if (bad || misses[s] >= fail_limit)
                health_tbl[s] = H_FAULTED;
            else if (sampled[s])
                health_tbl[s] = H_DEGRADED;
            else
                health_tbl[s] = H_STARTING;
        endfunction

        // Update the record for one accepted item and queue the reports it causes.
        function void note_item(logic f, logic [2:0] s, logic [1:0] st,
                                logic [31:0] r1, logic [15:0] r2, logic [63:0] t);
            logic        grant;
            logic [63:0] span;
            logic [31:0] limit;
            int          idx;
            grant = 1'b0;
            if (f == FUNC_TICK)
            begin
                for (int i = 0; i < SENSOR_COUNT; i++)
                begin
                    if (!sampled[i])
                        age_tbl[i] = AGE_MAX;
                    else
                    begin
                        limit = (i == DISTANCE_SENSORS) ? angle_fresh_ms : distance_fresh_ms;
                        // a sample stamped after the tick counts as brand new
                        span = (t >= sample_stamp[i]) ? t - sample_stamp[i] : 64'd0;
                        age_tbl[i] = (span > {32'd0, AGE_MAX}) ? AGE_MAX : span[31:0];
                        if (age_tbl[i] >= limit)
                        begin
                            if (misses[i] >= fail_limit)
                            begin
                                health_tbl[i] = H_FAULTED;
                                fault_tbl[i]  = F_STALE;
                            end
                            else
                                health_tbl[i] = H_DEGRADED;
                        end
                    end
                    expected_reports.push_back(snapshot(i, 1'b0, i == SENSOR_COUNT - 1));
                end
                return;
            end
            // unknown sensor: silently dropped
            if (s >= SENSOR_COUNT)
                return;
            idx = int'(s);
            case (status_t'(st))
                ST_OK:
                begin
                    reading_tbl[idx]     = r1;
                    reading_two_tbl[idx] = r2;
                    sample_stamp[idx]    = t;
                    sampled[idx]         = 1'b1;
                    fault_tbl[idx]       = F_NONE;
                    misses[idx]          = '0;
                    if (wins[idx] < STREAK_MAX)
                        wins[idx]++;
                    if (health_tbl[idx] == H_FAULTED || health_tbl[idx] == H_RECOVERING)
                        health_tbl[idx] = (wins[idx] >= recover_wins) ?
                                          H_HEALTHY : H_RECOVERING;
                    else
                        health_tbl[idx] = H_HEALTHY;
                end
                ST_BUS_STUCK:
                begin
                    count_failure(idx, F_BUS_STUCK);
                    span  = (t >= last_recovery_ms) ? t - last_recovery_ms : 64'd0;
                    grant = !recovered_once || (span >= {32'd0, cooldown_ms});
                    if (grant)
                    begin
                        last_recovery_ms = t;
                        recovered_once   = 1'b1;
                    end
                end
                ST_NO_ACK:    count_failure(idx, F_NO_ACK);
                ST_BUSY_SKIP: ;  // record untouched, report it as it stands
                default: ;
            endcase
            expected_reports.push_back(snapshot(idx, grant, 1'b1));
        endfunction

        function void check_report(health_report_t got);
            health_report_t want;
            string          diffs;
            if (expected_reports.size() == 0)
            begin
                complain({"unexpected result: ", show(got)});
                return;
            end
            want  = expected_reports.pop_front();
            diffs = "";
            if (got.which_sensor !== want.which_sensor)         diffs = {diffs, " which_sensor"};
            if (got.health !== want.health)                     diffs = {diffs, " health"};
            if (got.fault_code !== want.fault_code)             diffs = {diffs, " fault_code"};
            if (got.success_streak !== want.success_streak)     diffs = {diffs, " success_streak"};
            if (got.failure_streak !== want.failure_streak)     diffs = {diffs, " failure_streak"};
            if (got.age_ms !== want.age_ms)                     diffs = {diffs, " age_ms"};
            if (got.sample_seen !== want.sample_seen)           diffs = {diffs, " sample_seen"};
            if (got.last_reading !== want.last_reading)         diffs = {diffs, " last_reading"};
            if (got.last_reading_two !== want.last_reading_two) diffs = {diffs, " last_reading_two"};
            if (got.recover_request !== want.recover_request)   diffs = {diffs, " recover_request"};
            if (got.last !== want.last)                         diffs = {diffs, " last"};
            if (diffs != "")
                complain($sformatf("mismatch on%s\n  expected %s\n  actual   %s",
                                   diffs, show(want), show(got)));
        endfunction

        // Anything still queued here never came out of the block.
        function void drop_missing();
            while (expected_reports.size() != 0)
                complain({"missing result, expected ", show(expected_reports.pop_front())});
        endfunction

    endclass

endpackage

FILE: tb/sensor_health_tracker_unit_tb.sv
// Testbench top for sensor_health_tracker_unit: directed and random read
// outcomes and freshness ticks under several register settings and idle
// patterns. Depends on shtrk_pkg and shtrk_tb_pkg.
module sensor_health_tracker_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import shtrk_pkg::*;
    import shtrk_tb_pkg::*;

    // The slowest item is a tick, which produces five reports.
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT   = 200;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic        func             = FUNC_EVENT;
    logic [2:0]  sensor           = '0;
    logic [1:0]  status           = '0;
    logic [31:0] reading          = '0;
    logic [15:0] reading_two      = '0;
    logic [63:0] now_ms           = '0;
    logic        cfg_wr_en        = 1'b0;
    logic [2:0]  cfg_index        = '0;
    logic [31:0] cfg_wdata        = '0;
    logic        result_valid;
    logic [2:0]  which_sensor;
    logic [2:0]  health;
    logic [1:0]  fault_code;
    logic [7:0]  success_streak;
    logic [7:0]  failure_streak;
    logic [31:0] age_ms;
    logic        sample_seen;
    logic [31:0] last_reading;
    logic [15:0] last_reading_two;
    logic        recover_request;
    logic        last;

    // Running millisecond clock fed to the block; random phases move it
    // forward, backward and by large jumps.
    logic [63:0] stamp = '0;

    // Sender idle percentage per random phase. Receiver stalls do not exist
    // here, so the phases meant for them run without idling.
    int idle_plan [6] = '{0, 67, 0, 32, 67, 0};

    sensor_health_book book;

    sensor_health_tracker_unit dut (.*);

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Results cannot be held off: take every strobed report at the edge
    // that closes its cycle.
    always @(posedge clk)
    begin : watch_results
        health_report_t got;
        if (rst_n && result_valid === 1'b1)
        begin
            got.which_sensor     = which_sensor;
            got.health           = health;
            got.fault_code       = fault_code;
            got.success_streak   = success_streak;
            got.failure_streak   = failure_streak;
            got.age_ms           = age_ms;
            got.sample_seen      = sample_seen;
            got.last_reading     = last_reading;
            got.last_reading_two = last_reading_two;
            got.recover_request  = recover_request;
            got.last             = last;
            book.check_report(got);
        end
    end

    // Present one item and hold it until the block takes it. Start is left
    // high on purpose, so the caller either sends again or rests.
    task automatic send_item(input logic f, input logic [2:0] s, input logic [1:0] st,
                             input logic [31:0] r1, input logic [15:0] r2,
                             input logic [63:0] t);
        start       <= 1'b1;
        func        <= f;
        sensor      <= s;
        status      <= st;
        reading     <= r1;
        reading_two <= r2;
        now_ms      <= t;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        // transfer happened at this edge
        book.note_item(f, s, st, r1, r2, t);
    endtask

    task automatic rest(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stop sending, wait for every expected report, then let the block
    // settle so a dropped unknown-sensor item is surely finished.
    task automatic drain();
        int waited;
        start  <= 1'b0;
        waited = 0;
        while (book.pending() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        book.drop_missing();
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        book.set_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] thr, input logic [7:0] wins_needed,
                              input logic [31:0] cool, input logic [31:0] fresh_d,
                              input logic [31:0] fresh_a);
        write_reg(REG_FAULT_THRESHOLD, {24'd0, thr});
        write_reg(REG_RECOVERY_SUCCESSES, {24'd0, wins_needed});
        write_reg(REG_RECOVERY_COOLDOWN_MS, cool);
        write_reg(REG_DISTANCE_FRESH_MS, fresh_d);
        write_reg(REG_ANGLE_FRESH_MS, fresh_a);
    endtask

    // Random traffic. Most items come in runs of one outcome on one sensor,
    // which is what drives sensors through faulted, recovering and back;
    // the rest is scattered outcomes, ticks and unknown sensors.
    task automatic run_phase(input int items, input int idle_pct);
        int         done;
        int         run_left;
        int         pick;
        logic [2:0] run_sensor;
        logic [1:0] run_status;
        logic [2:0] who;
        logic [1:0] what;
        logic       is_tick;
        done       = 0;
        run_left   = 0;
        run_sensor = '0;
        run_status = ST_OK;
        while (done < items)
        begin
            // advance time: mostly small steps, sometimes back, sometimes far
            pick = $urandom_range(0, 99);
            if (pick < 3)
                stamp = {$urandom, $urandom};
            else if (pick < 8)
                stamp = stamp - 64'($urandom_range(1, 50));
            else if (pick < 12)
                stamp = stamp + 64'($urandom_range(0, 2000));
            else if (pick < 14)
                stamp = stamp + 64'h1_0000_0000 + 64'($urandom);
            else
                stamp = stamp + 64'($urandom_range(0, 40));

            if (run_left == 0 && $urandom_range(0, 99) < 40)
            begin
                run_left   = $urandom_range(2, 6);
                run_sensor = 3'($urandom_range(0, DISTANCE_SENSORS));
                pick       = $urandom_range(0, 2);
                run_status = (pick == 0) ? ST_OK : (pick == 1) ? ST_NO_ACK : ST_BUS_STUCK;
            end

            is_tick = 1'b0;
            if (run_left > 0)
            begin
                who  = run_sensor;
                what = run_status;
                run_left--;
            end
            else
            begin
                is_tick = ($urandom_range(0, 99) < 15);
                who     = ($urandom_range(0, 19) == 0) ?
                          3'($urandom_range(SENSOR_COUNT, 7)) :
                          3'($urandom_range(0, DISTANCE_SENSORS));
                what    = 2'($urandom_range(0, 3));
            end

            send_item(is_tick ? FUNC_TICK : FUNC_EVENT, who, what, $urandom,
                      16'($urandom), stamp);
            // dropped items do not count toward the phase
            if (is_tick || who < SENSOR_COUNT)
                done++;
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
                rest($urandom_range(1, 16));
        end
    endtask

    initial
    begin
        book = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset register values (threshold 3, successes 3,
        // cooldown 5000, distance limit 100, angle limit 1000).
        // Tick before any sample: every age reads all ones.
        send_item(FUNC_TICK, 3'd0, ST_OK, 32'd0, 16'd0, 64'd0);
        // unknown sensors: taken, no report
        send_item(FUNC_EVENT, 3'd5, ST_OK, 32'h1234_5678, 16'h9abc, 64'd0);
        send_item(FUNC_EVENT, 3'd7, ST_NO_ACK, 32'd0, 16'd0, 64'd0);
        // busy skip: report the untouched record
        send_item(FUNC_EVENT, 3'd2, ST_BUSY_SKIP, 32'hdead_beef, 16'hbeef, 64'd1);
        send_item(FUNC_EVENT, 3'd0, ST_OK, 32'hFFFF_FFFF, 16'hFFFF, 64'd10);
        send_item(FUNC_EVENT, 3'd4, ST_OK, 32'd0, 16'd0, 64'd20);
        // no sample yet: starting, then faulted at the third failure
        send_item(FUNC_EVENT, 3'd1, ST_NO_ACK, 32'd0, 16'd0, 64'd21);
        send_item(FUNC_EVENT, 3'd1, ST_NO_ACK, 32'd0, 16'd0, 64'd22);
        send_item(FUNC_EVENT, 3'd1, ST_NO_ACK, 32'd0, 16'd0, 64'd23);
        rest(3);
        // faulted -> recovering, first recovery request is always granted
        send_item(FUNC_EVENT, 3'd1, ST_OK, 32'h0000_0001, 16'h0002, 64'd30);
        send_item(FUNC_EVENT, 3'd1, ST_BUS_STUCK, 32'd0, 16'd0, 64'd40);
        send_item(FUNC_EVENT, 3'd1, ST_OK, 32'h0000_0011, 16'h0012, 64'd41);
        send_item(FUNC_EVENT, 3'd1, ST_OK, 32'h0000_0021, 16'h0022, 64'd42);
        send_item(FUNC_EVENT, 3'd1, ST_OK, 32'h0000_0031, 16'h0032, 64'd43);
        // cooldown: inside, past it, then time going backwards
        send_item(FUNC_EVENT, 3'd3, ST_BUS_STUCK, 32'd0, 16'd0, 64'd1000);
        send_item(FUNC_EVENT, 3'd3, ST_BUS_STUCK, 32'd0, 16'd0, 64'd6000);
        send_item(FUNC_EVENT, 3'd3, ST_BUS_STUCK, 32'd0, 16'd0, 64'd10);
        // failure with a sample: degraded
        send_item(FUNC_EVENT, 3'd0, ST_NO_ACK, 32'd0, 16'd0, 64'd50);
        send_item(FUNC_EVENT, 3'd0, ST_BUSY_SKIP, 32'd0, 16'd0, 64'd51);
        send_item(FUNC_EVENT, 3'd2, ST_OK, 32'h8000_0000, 16'h8000, 64'd60);
        send_item(FUNC_EVENT, 3'd2, ST_NO_ACK, 32'd0, 16'd0, 64'd61);
        send_item(FUNC_EVENT, 3'd2, ST_NO_ACK, 32'd0, 16'd0, 64'd62);
        send_item(FUNC_EVENT, 3'd2, ST_NO_ACK, 32'd0, 16'd0, 64'd63);
        // stale -> degraded; stale with failures at threshold -> stale fault;
        // age beyond 32 bits saturates; sample newer than the tick ages to 0
        send_item(FUNC_TICK, 3'd0, ST_OK, 32'd0, 16'd0, 64'd150);
        send_item(FUNC_TICK, 3'd0, ST_OK, 32'd0, 16'd0, 64'd300);
        send_item(FUNC_TICK, 3'd0, ST_OK, 32'd0, 16'd0, 64'hFFFF_FFFF_FFFF_0000);
        send_item(FUNC_TICK, 3'd0, ST_OK, 32'd0, 16'd0, 64'd5);
        drain();

        // Random phases. The first two pin every register at its extremes;
        // the rest pick settings where thresholds and staleness actually bite.
        stamp = 64'd1000;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: set_config(8'd0, 8'd0, 32'd0, 32'd0, 32'd0);
                1: set_config(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                default:
                    set_config(8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)),
                               32'($urandom_range(0, 200)), 32'($urandom_range(10, 300)),
                               32'($urandom_range(50, 1000)));
            endcase
            run_phase(42, idle_plan[p]);
            drain();
        end

        if (book.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
src/shtrk_pkg.sv
src/sensor_health_tracker_unit.sv
tb/shtrk_tb_pkg.sv
tb/sensor_health_tracker_unit_tb.sv
